>>> rtl/core/chist_pkg.sv
// Package for the character histogram block: word types, codes and defaults.
// Used by every module under rtl/core; depends on nothing else.
package chist_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int NUM_CODES_DEF   = 256;
  localparam int FIELD_W         = 16;

  localparam logic [7:0] FIRST_CHAR_RESET = 8'd33;
  localparam logic [7:0] LAST_CHAR_RESET  = 8'd126;

  localparam logic [1:0] MODE_COUNT  = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  // The fourth code is not assigned and behaves as a read.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic REG_FIRST_CHAR = 1'b0;
  localparam logic REG_LAST_CHAR  = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic [15:0] bin_count;
    logic        in_range;
    logic [15:0] total_chars;
    logic [15:0] max_count;
    logic [7:0]  max_char;
  } result_t;

  // State updates of one item, already gated by the stage advancing.
  typedef struct packed {
    logic count;  // byte counted into the total
    logic bin;    // byte bumps its bin
    logic clr;    // clear all bins and totals
  } upd_t;

endpackage

>>> rtl/core/chist_bins.sv
// Bin store of the character histogram: count memory, per-entry valid bits,
// and forwarding of the last write. Depends on chist_pkg.
module chist_bins
  import chist_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int NUM_CODES   = NUM_CODES_DEF,
  localparam int IDX_W      = $clog2(NUM_CODES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic [IDX_W-1:0]       rd_addr,
  input  logic [IDX_W-1:0]       addr,
  input  upd_t                   upd,
  input  logic [COUNT_WIDTH-1:0] wr_data,
  output logic [COUNT_WIDTH-1:0] old_count
);

  logic [COUNT_WIDTH-1:0] mem [NUM_CODES];
  logic [COUNT_WIDTH-1:0] rdata;
  logic [NUM_CODES-1:0]   vbit;
  logic                   fwd_valid;
  logic [IDX_W-1:0]       fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (upd.bin) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || upd.clr) begin
      vbit      <= '0;
      fwd_valid <= 1'b0;
    end else if (upd.bin) begin
      vbit[addr] <= 1'b1;
      fwd_valid  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.bin) begin
      fwd_addr <= addr;
      fwd_data <= wr_data;
    end
  end

  // A write that lands on the edge of the read is not in the read data, so
  // the last written word is taken instead.
  always_comb begin
    if (fwd_valid && fwd_addr == addr) begin
      old_count = fwd_data;
    end else if (vbit[addr]) begin
      old_count = rdata;
    end else begin
      old_count = '0;
    end
  end

endmodule

>>> rtl/core/chist_track.sv
// Running totals of the character histogram: byte count, greatest bin count
// and the lowest code holding it. Depends on chist_pkg.
module chist_track
  import chist_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  upd_t                   upd,
  input  logic [7:0]             code,
  input  logic [COUNT_WIDTH-1:0] new_count,
  output logic [COUNT_WIDTH-1:0] total_next,
  output logic [COUNT_WIDTH-1:0] best_count_next,
  output logic [7:0]             best_char_next
);

  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] best_count;
  logic [7:0]             best_char;

  always_comb begin
    total_next      = total;
    best_count_next = best_count;
    best_char_next  = best_char;
    if (upd.clr) begin
      total_next      = '0;
      best_count_next = '0;
      best_char_next  = '0;
    end else begin
      if (upd.count && total != '1) begin
        total_next = total + 1'b1;
      end
      if (upd.bin) begin
        if (new_count > best_count) begin
          best_count_next = new_count;
          best_char_next  = code;
        end else if (new_count == best_count && code < best_char) begin
          best_char_next = code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      best_count <= '0;
      best_char  <= '0;
    end else begin
      total      <= total_next;
      best_count <= best_count_next;
      best_char  <= best_char_next;
    end
  end

endmodule

>>> rtl/core/char_histogram_with_max.sv
// Top level of the character histogram with running maximum.
// Depends on chist_pkg, chist_bins and chist_track.
//
// The block takes one word per clock cycle while the result side does not
// stall and returns one result word for each through the update stage and
// the result register. The bin read is registered; the update stage forms
// the new count, writes it back and updates the totals, and a bin written
// on the cycle before is forwarded to the next word. Bins are emptied at
// reset and by a clear word through per-entry valid bits, so the block is
// ready at once after reset with no sweep of the memory. The range registers
// are to be written over the APB port while the block is idle (not enforced).
module char_histogram_with_max
  import chist_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int NUM_CODES   = NUM_CODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(NUM_CODES);
  localparam logic [8:0] CODE_LIMIT = 9'(NUM_CODES);

  logic [7:0] first_char;
  logic [7:0] last_char;

  logic                   accept;
  logic                   s1_valid;
  logic                   s1_fire;
  logic [1:0]             s1_mode;
  logic [7:0]             s1_code;
  logic                   s1_hit;
  logic                   s1_in_store;
  logic                   item_in_store;
  upd_t                   upd;
  logic [COUNT_WIDTH-1:0] bins_old;
  logic [COUNT_WIDTH-1:0] old_count;
  logic [COUNT_WIDTH-1:0] new_count;
  logic [COUNT_WIDTH-1:0] bin_after;
  logic [COUNT_WIDTH-1:0] total_next;
  logic [COUNT_WIDTH-1:0] best_count_next;
  logic [7:0]             best_char_next;
  logic [COUNT_WIDTH+FIELD_W-1:0] bin_wide;
  logic [COUNT_WIDTH+FIELD_W-1:0] total_wide;
  logic [COUNT_WIDTH+FIELD_W-1:0] best_wide;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_char <= FIRST_CHAR_RESET;
      last_char  <= LAST_CHAR_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_FIRST_CHAR: first_char <= pwdata[7:0];
        REG_LAST_CHAR:  last_char  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIRST_CHAR: prdata = {24'd0, first_char};
      REG_LAST_CHAR:  prdata = {24'd0, last_char};
      default:        prdata = '0;
    endcase
  end

  // Handshake: one word in the update stage and one in the result register.
  assign s1_fire    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_fire;
  assign accept     = item_valid && !item_stall;

  assign item_in_store = {1'b0, item.char_code} < CODE_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= item.mode;
      s1_code <= item.char_code;
    end
  end

  // Update stage.
  assign s1_hit      = (s1_code >= first_char) && (s1_code <= last_char);
  assign s1_in_store = {1'b0, s1_code} < CODE_LIMIT;

  always_comb begin
    upd = '0;
    if (s1_fire) begin
      case (s1_mode)
        MODE_COUNT: begin
          upd.count = 1'b1;
          upd.bin   = s1_hit && s1_in_store;
        end
        MODE_CLEAR: upd.clr = 1'b1;
        default: ;
      endcase
    end
  end

  assign old_count = s1_in_store ? bins_old : '0;
  assign new_count = (old_count == '1) ? old_count : old_count + 1'b1;

  always_comb begin
    if (s1_mode == MODE_CLEAR) begin
      bin_after = '0;
    end else if (s1_mode == MODE_COUNT && s1_hit && s1_in_store) begin
      bin_after = new_count;
    end else begin
      bin_after = old_count;
    end
  end

  chist_bins #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .NUM_CODES   (NUM_CODES)
  ) u_bins (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept && item_in_store),
    .rd_addr   (item.char_code[IDX_W-1:0]),
    .addr      (s1_code[IDX_W-1:0]),
    .upd       (upd),
    .wr_data   (new_count),
    .old_count (bins_old)
  );

  chist_track #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_track (
    .clk             (clk),
    .rst             (rst),
    .upd             (upd),
    .code            (s1_code),
    .new_count       (new_count),
    .total_next      (total_next),
    .best_count_next (best_count_next),
    .best_char_next  (best_char_next)
  );

  // Counts are zero-extended or cut to the 16-bit result fields.
  assign bin_wide   = {{FIELD_W{1'b0}}, bin_after};
  assign total_wide = {{FIELD_W{1'b0}}, total_next};
  assign best_wide  = {{FIELD_W{1'b0}}, best_count_next};

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result.bin_count   <= bin_wide[FIELD_W-1:0];
      result.in_range    <= s1_hit;
      result.total_chars <= total_wide[FIELD_W-1:0];
      result.max_count   <= best_wide[FIELD_W-1:0];
      result.max_char    <= best_char_next;
    end
  end

endmodule
